>>> design/foi_pkg.sv
// Shared types, constants and functions of the framed odometry integrator.
// No dependencies; every other file uses it by scoped names.
package foi_pkg;

  localparam int unsigned PayloadBytes = 8;
  localparam int unsigned CordicSteps  = 28;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [31:0] InvTwoPiQ32 = 32'd683565276;

  localparam logic [7:0]  StartReset = 8'hFF;
  localparam logic [7:0]  EndReset   = 8'hFE;
  localparam logic [31:0] TickReset  = 32'd4295;

  localparam logic [7:0] RegStart = 8'd0;
  localparam logic [7:0] RegEnd   = 8'd1;
  localparam logic [7:0] RegTick  = 8'd2;

  typedef struct packed {
    logic [31:0] raw_v;
    logic [31:0] raw_w;
    logic [31:0] stamp;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fq_stat_t;

  function automatic logic signed [20:0] single_to_q16(input logic [31:0] bits);
    logic [7:0]  e;
    logic [23:0] sig;
    logic [7:0]  sh;
    logic [23:0] mag;
    logic signed [20:0] res;
    e   = bits[30:23];
    sig = {1'b1, bits[22:0]};
    sh  = 8'd134 - e;
    mag = (sh >= 8'd24) ? 24'd0 : (sig >> sh[4:0]);
    if (e == 8'd0 || e == 8'd255 || e > 8'd130) begin
      res = '0;
    end else if (e == 8'd130 && sig >= 24'hA00000) begin
      res = '0;
    end else if (bits[31]) begin
      res = -$signed({1'b0, mag[19:0]});
    end else begin
      res = $signed({1'b0, mag[19:0]});
    end
    return res;
  endfunction

  function automatic logic [29:0] atan_bam(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      5'd24: r = 30'd41;
      5'd25: r = 30'd20;
      5'd26: r = 30'd10;
      5'd27: r = 30'd5;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/foi_framer.sv
// Front part: hunts for the start marker, collects the payload, checks the end marker.
// Depends on foi_pkg; pushes good frames into foi_fq.
module foi_framer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              stall_i,
  input  logic [7:0]        rx_byte_i,
  input  logic [31:0]       arrival_time_i,
  input  logic [7:0]        start_marker_i,
  input  logic [7:0]        end_marker_i,
  output logic              frame_push_o,
  output foi_pkg::frame_t   frame_o
);

  logic       in_frame_q, in_frame_d;
  logic [3:0] count_q, count_d;
  logic [7:0] payload_q [foi_pkg::PayloadBytes];
  logic       accept;
  logic       good_end;

  assign accept   = push_i && !stall_i;
  assign good_end = accept && in_frame_q && count_q[3] && (rx_byte_i == end_marker_i);

  always_comb begin
    in_frame_d = in_frame_q;
    count_d    = count_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (rx_byte_i == start_marker_i) begin
          in_frame_d = 1'b1;
          count_d    = '0;
        end
      end else if (!count_q[3]) begin
        count_d = count_q + 4'd1;
      end else if (rx_byte_i != end_marker_i) begin
        count_d = '0;
        if (rx_byte_i != start_marker_i) begin
          in_frame_d = 1'b0;
        end
      end else begin
        in_frame_d = 1'b0;
        count_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_frame_q && !count_q[3]) begin
      payload_q[count_q[2:0]] <= rx_byte_i;
    end
  end

  assign frame_push_o  = good_end;
  assign frame_o.raw_v = {payload_q[3], payload_q[2], payload_q[1], payload_q[0]};
  assign frame_o.raw_w = {payload_q[7], payload_q[6], payload_q[5], payload_q[4]};
  assign frame_o.stamp = arrival_time_i;

endmodule

>>> design/foi_fq.sv
// Two-entry queue of good frames between front and back parts.
// Depends on foi_pkg.
module foi_fq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  foi_pkg::frame_t     data_i,
  input  logic                pop_i,
  output foi_pkg::frame_t     data_o,
  output foi_pkg::fq_stat_t   stat_o
);

  foi_pkg::frame_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign stat_o.empty = (cnt_q == 2'd0);
  assign stat_o.full  = (cnt_q == 2'd2);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/foi_back.sv
// Back part: velocity conversion, CORDIC, wide products and pose integration.
// Depends on foi_pkg; takes frames from foi_fq, holds the result register.
module foi_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  foi_pkg::frame_t     frame_i,
  input  foi_pkg::fq_stat_t   fq_stat_i,
  output logic                fq_pop_o,
  input  logic [31:0]         tick_i,
  input  logic                pop_i,
  output logic                empty_o,
  output logic signed [47:0]  pos_x_o,
  output logic signed [47:0]  pos_y_o,
  output logic [31:0]         heading_o,
  output logic signed [20:0]  lin_vel_o,
  output logic signed [20:0]  ang_vel_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_DT, S_ROT, S_PRE, S_MUL, S_ADD, S_DONE
  } state_e;

  state_e state_q;
  logic signed [20:0] v_q, w_q;
  logic [31:0]  stamp_q, last_q, yaw_q;
  logic [63:0]  dt_q, pre_q;
  logic [127:0] acc_q;
  logic [47:0]  x_q, y_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [4:0]   it_q;
  logic [1:0]   op_q, pp_q;
  logic         neg_q;
  logic         out_valid_q;

  logic signed [33:0] dxs, dys, atn, c_fold, s_fold, k_sel;
  logic [32:0]  k_mag;
  logic [19:0]  v_mag, w_mag;
  logic [31:0]  ma, mb;
  logic [63:0]  prod;
  logic [127:0] prod_sh;
  logic [47:0]  mag48;
  logic [31:0]  mag32;
  logic         can_load;

  assign dxs = cy_q >>> it_q;
  assign dys = cx_q >>> it_q;
  assign atn = $signed({4'b0, foi_pkg::atan_bam(it_q)});

  always_comb begin
    case (yaw_q[31:30])
      2'd0:    begin c_fold = cx_q;  s_fold = cy_q;  end
      2'd1:    begin c_fold = -cy_q; s_fold = cx_q;  end
      2'd2:    begin c_fold = -cx_q; s_fold = -cy_q; end
      default: begin c_fold = cy_q;  s_fold = -cx_q; end
    endcase
  end

  assign k_sel = (op_q == 2'd0) ? c_fold : s_fold;
  assign k_mag = k_sel[33] ? 33'(-k_sel) : 33'(k_sel);
  assign v_mag = v_q[20] ? 20'(-v_q) : 20'(v_q);
  assign w_mag = w_q[20] ? 20'(-w_q) : 20'(w_q);

  always_comb begin
    case (pp_q)
      2'd0:    begin ma = pre_q[31:0];  mb = dt_q[31:0];  end
      2'd1:    begin ma = pre_q[31:0];  mb = dt_q[63:32]; end
      2'd2:    begin ma = pre_q[63:32]; mb = dt_q[31:0];  end
      default: begin ma = pre_q[63:32]; mb = dt_q[63:32]; end
    endcase
    prod = {32'b0, ma} * {32'b0, mb};
    case (pp_q)
      2'd0:    prod_sh = {64'b0, prod};
      2'd3:    prod_sh = {prod, 64'b0};
      default: prod_sh = {32'b0, prod, 32'b0};
    endcase
  end

  assign mag48    = neg_q ? 48'(-acc_q[109:62]) : acc_q[109:62];
  assign mag32    = neg_q ? 32'(-acc_q[79:48]) : acc_q[79:48];
  assign can_load = !out_valid_q || pop_i;
  assign fq_pop_o = (state_q == S_IDLE) && !fq_stat_i.empty;
  assign empty_o  = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      x_q         <= '0;
      y_q         <= '0;
      yaw_q       <= '0;
      it_q        <= '0;
      op_q        <= '0;
      pp_q        <= '0;
    end else begin
      if (pop_i && out_valid_q) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (!fq_stat_i.empty) begin
            v_q     <= foi_pkg::single_to_q16(frame_i.raw_v);
            w_q     <= foi_pkg::single_to_q16(frame_i.raw_w);
            stamp_q <= frame_i.stamp;
            state_q <= S_DT;
          end
        end
        S_DT: begin
          dt_q    <= {32'b0, stamp_q - last_q} * {32'b0, tick_i};
          cx_q    <= foi_pkg::CordicGain;
          cy_q    <= '0;
          cz_q    <= $signed({4'b0, yaw_q[29:0]});
          it_q    <= '0;
          state_q <= S_ROT;
        end
        S_ROT: begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - dxs;
            cy_q <= cy_q + dys;
            cz_q <= cz_q - atn;
          end else begin
            cx_q <= cx_q + dxs;
            cy_q <= cy_q - dys;
            cz_q <= cz_q + atn;
          end
          it_q <= it_q + 5'd1;
          if (it_q == 5'(foi_pkg::CordicSteps - 1)) begin
            op_q    <= '0;
            state_q <= S_PRE;
          end
        end
        S_PRE: begin
          if (op_q == 2'd2) begin
            pre_q <= {44'b0, w_mag} * {32'b0, foi_pkg::InvTwoPiQ32};
            neg_q <= w_q[20];
          end else begin
            pre_q <= {44'b0, v_mag} * {31'b0, k_mag};
            neg_q <= v_q[20] != k_sel[33];
          end
          acc_q   <= '0;
          pp_q    <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          acc_q <= acc_q + prod_sh;
          pp_q  <= pp_q + 2'd1;
          if (pp_q == 2'd3) state_q <= S_ADD;
        end
        S_ADD: begin
          case (op_q)
            2'd0:    x_q   <= x_q + mag48;
            2'd1:    y_q   <= y_q + mag48;
            default: yaw_q <= yaw_q + mag32;
          endcase
          op_q    <= op_q + 2'd1;
          state_q <= (op_q == 2'd2) ? S_DONE : S_PRE;
        end
        S_DONE: begin
          if (can_load) begin
            pos_x_o     <= $signed(x_q);
            pos_y_o     <= $signed(y_q);
            heading_o   <= yaw_q;
            lin_vel_o   <= v_q;
            ang_vel_o   <= w_q;
            out_valid_q <= 1'b1;
            last_q      <= stamp_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_rot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ROT |-> it_q < 5'(foi_pkg::CordicSteps))
    else $error("cordic step count overran");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && $stable(pos_x_o) && $stable(heading_o))
    else $error("waiting result changed");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_pop_o |=> state_q == S_DT)
    else $error("frame taken outside idle");

endmodule

>>> design/framed_odometry_integrator.sv
// Top level of the framed odometry integrator: configuration registers and wiring.
// Depends on foi_pkg, foi_framer, foi_fq and foi_back.
//
// channel   handshake              payload
// input     push_i / full_o        rx_byte_i, arrival_time_i
// result    pop_i / empty_o        pos_x_o, pos_y_o, heading_o, lin_vel_o, ang_vel_o
// config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A byte is taken each cycle while the two-entry frame queue has room.
// In the back end a good frame takes 28 CORDIC steps on one shared
// rotator, then three products, each with setup, four partial products
// on one 32x32 multiplier and accumulate, plus take, dt and load states.
// Reset clears framing, pose and queues; config returns to its reset values.
// A waiting result holds the back end only at its final load.
module framed_odometry_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         rx_byte_i,
  input  logic [31:0]        arrival_time_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [20:0] lin_vel_o,
  output logic signed [20:0] ang_vel_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  logic [7:0]  start_q, end_q;
  logic [31:0] tick_q;
  logic        frame_push, fq_pop;
  foi_pkg::frame_t   frame_in, frame_out;
  foi_pkg::fq_stat_t fq_stat;

  assign cfg_ready_o = 1'b1;
  assign full_o      = fq_stat.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= foi_pkg::StartReset;
      end_q   <= foi_pkg::EndReset;
      tick_q  <= foi_pkg::TickReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        foi_pkg::RegStart: start_q <= cfg_data_i[7:0];
        foi_pkg::RegEnd:   end_q   <= cfg_data_i[7:0];
        foi_pkg::RegTick:  tick_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  foi_framer u_framer (
    .clk_i, .rst_ni,
    .push_i,
    .stall_i        (fq_stat.full),
    .rx_byte_i,
    .arrival_time_i,
    .start_marker_i (start_q),
    .end_marker_i   (end_q),
    .frame_push_o   (frame_push),
    .frame_o        (frame_in)
  );

  foi_fq u_fq (
    .clk_i, .rst_ni,
    .push_i (frame_push),
    .data_i (frame_in),
    .pop_i  (fq_pop),
    .data_o (frame_out),
    .stat_o (fq_stat)
  );

  foi_back u_back (
    .clk_i, .rst_ni,
    .frame_i   (frame_out),
    .fq_stat_i (fq_stat),
    .fq_pop_o  (fq_pop),
    .tick_i    (tick_q),
    .pop_i,
    .empty_o,
    .pos_x_o,
    .pos_y_o,
    .heading_o,
    .lin_vel_o,
    .ang_vel_o
  );

endmodule
